@@ sv/sdg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sidechain ducking gain package
// Shared constants and register codes for the sidechain ducker.
// ----------------------------------------------------------------------------
package sdg_pkg;

  // Unity gain in Q1.23.
  localparam logic [23:0] UNITY_GAIN    = 24'd8388608;
  // Lowest usable threshold, minus 96 dB in Q0.23.
  localparam logic [22:0] MIN_THRESHOLD = 23'd133;
  // (20 * log10(2)) / 24 in Q0.24 scaled for a Q.16 log difference.
  localparam logic [22:0] DB_OCT_OVER_24 = 23'd4208704;
  // Fraction bits produced by the log2 unit.
  localparam int LOG_FRAC_BITS = 16;

  // Shared multiplier operand and product widths.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Configuration register indexes.
  localparam logic [2:0] REG_ENABLED          = 3'd0;
  localparam logic [2:0] REG_THRESHOLD_LEVEL  = 3'd1;
  localparam logic [2:0] REG_DUCK_SCALE       = 3'd2;
  localparam logic [2:0] REG_DETECTOR_ATTACK  = 3'd3;
  localparam logic [2:0] REG_DETECTOR_RELEASE = 3'd4;
  localparam logic [2:0] REG_DUCK_ATTACK      = 3'd5;
  localparam logic [2:0] REG_DUCK_RELEASE     = 3'd6;
  localparam logic [2:0] REG_HOLD_SAMPLES     = 3'd7;

endpackage

@@ sv/sdg_peak.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sidechain peak detector
// Largest magnitude among the present sidechain sources, in Q.23.
// ----------------------------------------------------------------------------
module sdg_peak #(
  parameter int NUM_SOURCES = 4,
  parameter int SAMPLE_BITS = 24
) (
  input  logic signed [SAMPLE_BITS-1:0] source_a,
  input  logic signed [SAMPLE_BITS-1:0] source_b,
  input  logic signed [SAMPLE_BITS-1:0] source_c,
  input  logic signed [SAMPLE_BITS-1:0] source_d,
  input  logic        [3:0]             source_mask,
  output logic        [23:0]            peak
);

  localparam int SH_R = (SAMPLE_BITS > 24) ? SAMPLE_BITS - 24 : 0;
  localparam int SH_L = (SAMPLE_BITS < 24) ? 24 - SAMPLE_BITS : 0;

  logic signed [SAMPLE_BITS-1:0] src [4];

  assign src[0] = source_a;
  assign src[1] = source_b;
  assign src[2] = source_c;
  assign src[3] = source_d;

  // Compare scaled magnitudes of the present sources.
  always_comb begin
    logic [SAMPLE_BITS-1:0] mag;
    logic [23:0]            scaled;
    peak = '0;
    for (int k = 0; k < 4; k++) begin
      mag    = src[k][SAMPLE_BITS-1] ? SAMPLE_BITS'(-src[k]) : SAMPLE_BITS'(src[k]);
      scaled = 24'(({24'd0, mag} << SH_L) >> SH_R);
      if (k < NUM_SOURCES && source_mask[k] && scaled > peak) begin
        peak = scaled;
      end
    end
  end

endmodule

@@ sv/sdg_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier with a registered product, reused by the sequencer.
// ----------------------------------------------------------------------------
module sdg_mul (
  input  logic                              clk,
  input  logic signed [sdg_pkg::MUL_W-1:0]  op_a,
  input  logic signed [sdg_pkg::MUL_W-1:0]  op_b,
  output logic signed [sdg_pkg::PROD_W-1:0] prod
);

  // The product is registered and ready in the cycle after the operands are presented.
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

@@ sv/sidechain_ducking_gain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sidechain ducking gain
// Peak follower with hold, log2 based duck amount and smoothed stereo gain.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  input    | in_valid / in_ready   | left_in, right_in, source_a..d, mask
//  output   | out_valid / out_ready | left_out, right_out, gain_now
//  config   | cfg_we                | cfg_index, cfg_data
//
//  A request passes through at unity gain when disabled. When enabled,
//  the two 16-step log2 squarings on the shared multiplier run only
//  when the envelope is over the threshold.
//  Reset is synchronous and restores the state, the configuration, the
//  filter state and the output handshake flags. A finished result waits in
//  the output register while the next request is already taken; it stalls only if that one finishes first.
// ----------------------------------------------------------------------------
module sidechain_ducking_gain #(
  parameter int NUM_SOURCES = 4,
  parameter int SAMPLE_BITS = 24,
  parameter int HOLD_BITS   = 21
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [SAMPLE_BITS-1:0]    left_in,
  input  logic signed [SAMPLE_BITS-1:0]    right_in,
  input  logic signed [SAMPLE_BITS-1:0]    source_a,
  input  logic signed [SAMPLE_BITS-1:0]    source_b,
  input  logic signed [SAMPLE_BITS-1:0]    source_c,
  input  logic signed [SAMPLE_BITS-1:0]    source_d,
  input  logic        [3:0]                source_mask,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [SAMPLE_BITS-1:0]    left_out,
  output logic signed [SAMPLE_BITS-1:0]    right_out,
  output logic        [23:0]               gain_now,
  input  logic                             cfg_we,
  input  logic        [2:0]                cfg_index,
  input  logic        [((HOLD_BITS > 24) ? HOLD_BITS : 24)-1:0] cfg_data
);

  localparam int MW = sdg_pkg::MUL_W;
  localparam int PW = sdg_pkg::PROD_W;

  typedef enum logic [4:0] {
    S_IDLE, S_ENV_A, S_ENV_B, S_ENV_C, S_LOG_INIT, S_LOG_SQ, S_LOG_UP,
    S_AMT_A, S_AMT_B, S_RED_A, S_RED_B, S_GAIN_A, S_GAIN_B, S_GAIN_C,
    S_OUT_A, S_OUT_B, S_OUT_C
  } state_t;

  // Extra state for the final write to the output register.
  logic   out_pend;
  state_t state;

  // Configuration registers.
  logic                 enabled;
  logic [22:0]          threshold_level;
  logic [23:0]          duck_scale;
  logic [23:0]          detector_attack;
  logic [23:0]          detector_release;
  logic [23:0]          duck_attack;
  logic [23:0]          duck_release;
  logic [HOLD_BITS-1:0] hold_samples;

  // Filter state.
  logic [23:0]          envelope;
  logic [23:0]          smoothed_gain;
  logic [HOLD_BITS-1:0] hold_count;

  // Working registers.
  logic signed [SAMPLE_BITS-1:0] left_q, right_q, left_res, right_res;
  logic [23:0] gain_res;
  logic [23:0] peak;
  logic [23:0] env_coef;
  logic        env_upd;
  logic [49:0] acc;
  logic [23:0] log_val;
  logic        log_sel;
  logic [4:0]  lg_e;
  logic [30:0] lg_m;
  logic [15:0] lg_frac;
  logic [3:0]  lg_cnt;
  logic [20:0] log_env;
  logic [20:0] log_diff;
  logic [24:0] amount;
  logic [23:0] target;

  // Combinational helpers.
  logic [23:0]          peak_c;
  logic [22:0]          thr;
  logic [23:0]          scale;
  logic [23:0]          gain_coef;
  logic [24:0]          coef_cmp;
  logic [HOLD_BITS-1:0] hold_next;
  logic [49:0]          pole_sum;
  logic [23:0]          pole_new;
  logic [23:0]          env_eff;
  logic [31:0]          sq;
  logic [15:0]          frac_next;
  logic [30:0]          m_next;
  logic [20:0]          log_res;
  logic [4:0]           norm_e;
  logic [30:0]          norm_m;
  logic [PW-1:0]        out_sum;
  logic [27:0]          amt_raw;
  logic signed [MW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod;

  sdg_peak #(
    .NUM_SOURCES (NUM_SOURCES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_peak (
    .source_a    (source_a),
    .source_b    (source_b),
    .source_c    (source_c),
    .source_d    (source_d),
    .source_mask (source_mask),
    .peak        (peak_c)
  );

  sdg_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign in_ready = (state == S_IDLE) && !out_pend;

  // Effective threshold, scale, hold decision and gain coefficient.
  always_comb begin
    thr   = (threshold_level < sdg_pkg::MIN_THRESHOLD) ? sdg_pkg::MIN_THRESHOLD
                                                       : threshold_level;
    scale = (duck_scale > sdg_pkg::UNITY_GAIN) ? sdg_pkg::UNITY_GAIN : duck_scale;
    if ({1'b0, peak_c} > {2'b0, thr}) begin
      hold_next = hold_samples;
    end else if (hold_count != '0) begin
      hold_next = hold_count - HOLD_BITS'(1);
    end else begin
      hold_next = '0;
    end
    gain_coef = (target < smoothed_gain) ? duck_attack : duck_release;
  end

  // One-pole filter, log2 step, normalization, amount slice and output rounding.
  always_comb begin
    coef_cmp  = (state == S_ENV_B) ? 25'(25'h1000000 - {1'b0, env_coef})
                                   : 25'(25'h1000000 - {1'b0, gain_coef});
    pole_sum  = acc + 50'(prod[49:0]) + 50'h800000;
    pole_new  = pole_sum[47:24];
    env_eff   = env_upd ? pole_new : envelope;
    sq        = prod[61:30];
    frac_next = {lg_frac[14:0], sq[31]};
    m_next    = sq[31] ? sq[31:1] : sq[30:0];
    log_res   = {lg_e, frac_next};
    out_sum   = PW'(prod) + PW'(1 << 22);
    amt_raw   = prod[43:16];
    norm_e    = '0;
    for (int i = 0; i < 24; i++) begin
      if (log_val[i]) norm_e = 5'(i);
    end
    norm_m = 31'({7'd0, log_val} << (5'd30 - norm_e));
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state)
      S_ENV_A: begin
        op_a = MW'(env_coef);
        op_b = MW'(envelope);
      end
      S_ENV_B: begin
        op_a = MW'(coef_cmp);
        op_b = MW'(peak);
      end
      S_LOG_SQ: begin
        op_a = MW'(lg_m);
        op_b = MW'(lg_m);
      end
      S_AMT_A: begin
        op_a = MW'(log_diff);
        op_b = MW'(sdg_pkg::DB_OCT_OVER_24);
      end
      S_RED_A: begin
        op_a = MW'(amount);
        op_b = MW'(scale);
      end
      S_GAIN_A: begin
        op_a = MW'(gain_coef);
        op_b = MW'(smoothed_gain);
      end
      S_GAIN_B: begin
        op_a = MW'(coef_cmp);
        op_b = MW'(target);
      end
      S_OUT_A: begin
        op_a = MW'(left_q);
        op_b = MW'(smoothed_gain);
      end
      S_OUT_B: begin
        op_a = MW'(right_q);
        op_b = MW'(smoothed_gain);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Sequencer, state, configuration and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_pend         <= 1'b0;
      out_valid        <= 1'b0;
      enabled          <= 1'b0;
      threshold_level  <= 23'd265271;
      duck_scale       <= '0;
      detector_attack  <= 24'd16431270;
      detector_release <= 24'd16431270;
      duck_attack      <= 24'd16431270;
      duck_release     <= 24'd16431270;
      hold_samples     <= '0;
      envelope         <= '0;
      smoothed_gain    <= sdg_pkg::UNITY_GAIN;
      hold_count       <= '0;
    end else begin
      // Move a finished result into the output register.
      if (out_pend && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        out_pend  <= 1'b0;
        left_out  <= left_res;
        right_out <= right_res;
        gain_now  <= gain_res;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            left_q  <= left_in;
            right_q <= right_in;
            if (!enabled) begin
              smoothed_gain <= sdg_pkg::UNITY_GAIN;
              left_res      <= left_in;
              right_res     <= right_in;
              gain_res      <= sdg_pkg::UNITY_GAIN;
              out_pend      <= 1'b1;
            end else begin
              peak       <= peak_c;
              hold_count <= hold_next;
              env_coef   <= (peak_c > envelope) ? detector_attack : detector_release;
              env_upd    <= (peak_c > envelope) || (hold_next == '0);
              state      <= S_ENV_A;
            end
          end
        end
        S_ENV_A: state <= S_ENV_B;
        S_ENV_B: begin
          acc   <= prod[49:0];
          state <= S_ENV_C;
        end
        S_ENV_C: begin
          if (env_upd) envelope <= pole_new;
          if (env_eff > {1'b0, thr}) begin
            log_val <= env_eff;
            log_sel <= 1'b0;
            state   <= S_LOG_INIT;
          end else begin
            target <= sdg_pkg::UNITY_GAIN;
            state  <= S_GAIN_A;
          end
        end
        S_LOG_INIT: begin
          lg_e    <= norm_e;
          lg_m    <= norm_m;
          lg_frac <= '0;
          lg_cnt  <= '0;
          state   <= S_LOG_SQ;
        end
        S_LOG_SQ: state <= S_LOG_UP;
        S_LOG_UP: begin
          lg_m    <= m_next;
          lg_frac <= frac_next;
          lg_cnt  <= lg_cnt + 4'd1;
          if (lg_cnt == 4'(sdg_pkg::LOG_FRAC_BITS - 1)) begin
            if (!log_sel) begin
              log_env <= log_res;
              log_val <= {1'b0, thr};
              log_sel <= 1'b1;
              state   <= S_LOG_INIT;
            end else begin
              log_diff <= log_env - log_res;
              state    <= S_AMT_A;
            end
          end else begin
            state <= S_LOG_SQ;
          end
        end
        S_AMT_A: state <= S_AMT_B;
        S_AMT_B: begin
          amount <= (amt_raw > 28'h1000000) ? 25'h1000000 : amt_raw[24:0];
          state  <= S_RED_A;
        end
        S_RED_A: state <= S_RED_B;
        S_RED_B: begin
          target <= 24'(sdg_pkg::UNITY_GAIN - 24'((prod[48:0] + 49'h800000) >> 24));
          state  <= S_GAIN_A;
        end
        S_GAIN_A: state <= S_GAIN_B;
        S_GAIN_B: begin
          acc   <= prod[49:0];
          state <= S_GAIN_C;
        end
        S_GAIN_C: begin
          smoothed_gain <= pole_new;
          state         <= S_OUT_A;
        end
        S_OUT_A: state <= S_OUT_B;
        S_OUT_B: begin
          left_res <= out_sum[SAMPLE_BITS+22:23];
          state    <= S_OUT_C;
        end
        // The right channel product lands in the cycle after the left one.
        S_OUT_C: begin
          right_res <= out_sum[SAMPLE_BITS+22:23];
          gain_res  <= smoothed_gain;
          state     <= S_IDLE;
          out_pend  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase

      // Register writes.
      if (cfg_we) begin
        unique case (cfg_index)
          sdg_pkg::REG_ENABLED:          enabled          <= cfg_data[0];
          sdg_pkg::REG_THRESHOLD_LEVEL:  threshold_level  <= cfg_data[22:0];
          sdg_pkg::REG_DUCK_SCALE:       duck_scale       <= cfg_data[23:0];
          sdg_pkg::REG_DETECTOR_ATTACK:  detector_attack  <= cfg_data[23:0];
          sdg_pkg::REG_DETECTOR_RELEASE: detector_release <= cfg_data[23:0];
          sdg_pkg::REG_DUCK_ATTACK:      duck_attack      <= cfg_data[23:0];
          sdg_pkg::REG_DUCK_RELEASE:     duck_release     <= cfg_data[23:0];
          sdg_pkg::REG_HOLD_SAMPLES: begin
            hold_samples <= cfg_data[HOLD_BITS-1:0];
            if (hold_count > cfg_data[HOLD_BITS-1:0]) begin
              hold_count <= cfg_data[HOLD_BITS-1:0];
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ sv/sdg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sidechain ducking gain checker
// Port level checks on the request channels of the ducker.
// ----------------------------------------------------------------------------
module sdg_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] left_out,
  input logic signed [SAMPLE_BITS-1:0] right_out,
  input logic        [23:0]            gain_now
);

  // No result is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_out) &&
      $stable(right_out) && $stable(gain_now))
    else $error("stalled result changed");

  // The applied gain never exceeds unity.
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gain_now <= sdg_pkg::UNITY_GAIN)
    else $error("gain above unity");

  // One request is worked on at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

endmodule

bind sidechain_ducking_gain sdg_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sdg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .left_out  (left_out),
  .right_out (right_out),
  .gain_now  (gain_now)
);
